// File: rtl/core/bpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_pkg - shared definitions for the bicycle pose delta pipeline
// Fixed point constants, the CORDIC arctangent table, stage numbering,
// the per-item pipeline record and the saturation and folding helpers.
// ----------------------------------------------------------------------------
package bpd_pkg;

    // Register map and reset values
    localparam logic [1:0]  REG_WHEEL_BASE  = 2'd0;
    localparam logic [1:0]  REG_REAR_OFFSET = 2'd1;
    localparam logic [1:0]  REG_STEP_TIME   = 2'd2;
    localparam logic [15:0] WHEEL_BASE_RST  = 16'd4096;
    localparam logic [15:0] REAR_OFFSET_RST = 16'd0;
    localparam logic [15:0] STEP_TIME_RST   = 16'd3277;

    // Angles in Q30 radians
    localparam int ZW = 35;
    localparam logic signed [ZW-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [ZW-1:0] Q30_TWO_PI  = 35'sd6746518852;
    localparam logic [63:0]          TWO_PI_U    = 64'd6746518852;
    localparam logic [32:0]          TWO_PI_33   = 33'd6746518852;
    localparam logic signed [33:0]   CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0]   ONE_Q30     = 34'sd1073741824;
    localparam logic signed [63:0]   LIM         = 64'sh4000_0000_0000_0000;

    // floor(2^64 / (2*pi in Q30)), the reciprocal used for the angle reduction
    localparam logic [31:0] RECIP_2PI = 32'((128'd1 << 64) / 128'(TWO_PI_U));

    localparam int NSTEPS = 30;
    localparam logic signed [33:0] ATAN_TAB [NSTEPS] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,
        34'sd64,        34'sd32,        34'sd16,        34'sd8,
        34'sd4,         34'sd2
    };

    // Stage numbering
    localparam int DIV_BITS  = 64;
    localparam int STG_C1    = 1;
    localparam int STG_UM    = STG_C1 + NSTEPS;
    localparam int STG_DP    = STG_UM + 1;
    localparam int STG_DIV   = STG_DP + 1;
    localparam int STG_G     = STG_DIV + DIV_BITS;
    localparam int STG_M2    = STG_G + 1;
    localparam int STG_R2    = STG_M2 + 1;
    localparam int STG_M3    = STG_R2 + 1;
    localparam int STG_R3    = STG_M3 + 1;
    localparam int STG_MA    = STG_R3 + 1;
    localparam int STG_RP    = STG_MA + 1;
    localparam int STG_RQ    = STG_RP + 1;
    localparam int STG_RM    = STG_RQ + 1;
    localparam int STG_RC    = STG_RM + 1;
    localparam int STG_F2    = STG_RC + 1;
    localparam int STG_C2    = STG_F2 + 1;
    localparam int STG_M4    = STG_C2 + NSTEPS;
    localparam int STG_R4    = STG_M4 + 1;
    localparam int STG_OUT   = STG_R4 + 1;
    localparam int NSTG      = STG_OUT + 1;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [33:0] z;
        logic               flip;
    } fold_t;

    // Everything one request carries down the pipe
    typedef struct packed {
        logic signed [15:0] spd;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
        logic signed [33:0] ss;
        logic signed [49:0] uprod;
        logic signed [50:0] den;
        logic signed [33:0] u;
        logic [63:0]        dnum;
        logic [47:0]        dden;
        logic [47:0]        rem;
        logic [63:0]        q;
        logic               gneg;
        logic               gzero;
        logic signed [63:0] g;
        logic signed [66:0] pgh;
        logic signed [65:0] pgl;
        logic signed [79:0] pt;
        logic signed [50:0] pwd;
        logic signed [63:0] w;
        logic signed [63:0] t;
        logic signed [35:0] wd;
        logic signed [80:0] pw;
        logic signed [68:0] pth;
        logic signed [67:0] ptl;
        logic signed [31:0] dh;
        logic signed [63:0] p;
        logic signed [63:0] wt;
        logic [62:0]        mr;
        logic               pneg;
        logic [63:0]        rph;
        logic [62:0]        rpl;
        logic [30:0]        rq;
        logic [63:0]        rqc;
        logic signed [69:0] cpa;
        logic signed [69:0] spa;
        logic signed [66:0] wch;
        logic signed [65:0] wcl;
        logic signed [66:0] wsh;
        logic signed [65:0] wsl;
        logic signed [63:0] a1;
        logic signed [63:0] b1;
        logic signed [63:0] a2;
        logic signed [63:0] b2;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } item_t;

    // Clamp to +-2^62
    function automatic logic signed [63:0] sat62(input wide_t v);
        if (v > wide_t'(LIM)) begin
            return LIM;
        end else if (v < -wide_t'(LIM)) begin
            return -LIM;
        end
        return v[63:0];
    endfunction

    // Clamp to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -65'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Wrap into [-pi, pi] then fold into [-pi/2, pi/2]
    function automatic fold_t fold_angle(input logic signed [ZW-1:0] a);
        logic signed [ZW-1:0] r;
        fold_t                f;
        r      = a;
        f.flip = 1'b0;
        if (r > Q30_PI) begin
            r = r - Q30_TWO_PI;
        end else if (r < -Q30_PI) begin
            r = r + Q30_TWO_PI;
        end
        if (r > Q30_HALF_PI) begin
            r      = r - Q30_PI;
            f.flip = 1'b1;
        end else if (r < -Q30_HALF_PI) begin
            r      = r + Q30_PI;
            f.flip = 1'b1;
        end
        f.z = r[33:0];
        return f;
    endfunction

endpackage

// File: rtl/core/bicycle_pose_delta.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle unless the result is stalled; set by
// the fully pipelined CORDICs, the 64-stage restoring divider and the
// reciprocal-multiply angle reduction.
// A stalled result holds the whole pipe; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// register defaults: wheel base 1.0 m, rear offset 0, step 3277/65536 s.
// ----------------------------------------------------------------------------
// bicycle_pose_delta - kinematic bicycle pose change over one time step
// Slip and yaw rate from steering via CORDIC, tan/L by long division,
// then dx, dy and dheading at the mid-step heading, all saturated.
// ----------------------------------------------------------------------------
module bicycle_pose_delta (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] speed, [31:16] steer_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // [31:0] delta_x, [63:32] delta_y,
                                    // [95:64] delta_heading
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bpd_pkg::*;

    logic [15:0]     wb_reg;
    logic [15:0]     ro_reg;
    logic [15:0]     dt_reg;
    logic [15:0]     len;
    logic [NSTG-1:0] vld_reg;
    logic            pipe_en;
    item_t           pipe_reg  [NSTG];
    item_t           pipe_next [NSTG];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg <= WHEEL_BASE_RST;
            ro_reg <= REAR_OFFSET_RST;
            dt_reg <= STEP_TIME_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WHEEL_BASE:  wb_reg <= cfg_data;
                REG_REAR_OFFSET: ro_reg <= cfg_data;
                REG_STEP_TIME:   dt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A zero wheel base counts as one LSB
    assign len = (wb_reg == '0) ? 16'd1 : wb_reg;

    // Global advance: the pipe moves unless the result is stalled
    assign pipe_en  = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {pipe_reg[NSTG-1].dh, pipe_reg[NSTG-1].dy, pipe_reg[NSTG-1].dx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pipe_reg <= pipe_next;
        end
    end

    // Capture: steering angle into Q30 and fold for the CORDIC
    always_comb begin
        item_t it;
        fold_t f;
        it      = '0;
        f       = fold_angle({{2{s_tdata[31]}}, s_tdata[31:16], 17'd0});
        it.spd  = s_tdata[15:0];
        it.x    = CORDIC_GAIN;
        it.y    = '0;
        it.z    = f.z;
        it.flip = f.flip;
        pipe_next[0] = it;
    end

    // Rotation-mode CORDIC, one micro-rotation per stage (steer, then mid angle)
    for (genvar c = 0; c < 2; c++) begin : g_cordic
        for (genvar i = 0; i < NSTEPS; i++) begin : g_step
            localparam int N = ((c == 0) ? STG_C1 : STG_C2) + i;
            item_t              nxt;
            logic signed [33:0] xs;
            logic signed [33:0] ys;
            always_comb begin
                nxt = pipe_reg[N-1];
                xs  = pipe_reg[N-1].x >>> i;
                ys  = pipe_reg[N-1].y >>> i;
                if (!pipe_reg[N-1].z[33]) begin
                    nxt.x = pipe_reg[N-1].x - ys;
                    nxt.y = pipe_reg[N-1].y + xs;
                    nxt.z = pipe_reg[N-1].z - ATAN_TAB[i];
                end else begin
                    nxt.x = pipe_reg[N-1].x + ys;
                    nxt.y = pipe_reg[N-1].y - xs;
                    nxt.z = pipe_reg[N-1].z + ATAN_TAB[i];
                end
            end
            assign pipe_next[N] = nxt;
        end
    end

    // U numerator and divisor L*cos(s)
    always_comb begin
        item_t              it;
        logic signed [33:0] cs;
        it    = pipe_reg[STG_UM-1];
        cs    = it.flip ? -it.x : it.x;
        it.ss = it.flip ? -it.y : it.y;
        it.uprod = it.spd * (ONE_Q30 + cs);
        it.den   = $signed({1'b0, len}) * cs;
        pipe_next[STG_UM] = it;
    end

    // Divider operands as magnitudes with a result sign
    always_comb begin
        item_t              it;
        logic signed [33:0] sa;
        logic signed [50:0] da;
        it       = pipe_reg[STG_DP-1];
        it.u     = it.uprod[49:16];
        sa       = it.ss[33] ? -it.ss : it.ss;
        da       = it.den[50] ? -it.den : it.den;
        it.dnum  = {sa[31:0], 32'd0};
        it.dden  = da[47:0];
        it.gneg  = it.ss[33] ^ it.den[50];
        it.gzero = (it.ss == '0);
        it.rem   = '0;
        it.q     = '0;
        pipe_next[STG_DP] = it;
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        localparam int N = STG_DIV + j;
        item_t       nxt;
        logic [48:0] trial;
        logic [48:0] diff;
        always_comb begin
            nxt   = pipe_reg[N-1];
            trial = {pipe_reg[N-1].rem, pipe_reg[N-1].dnum[63]};
            diff  = trial - {1'b0, pipe_reg[N-1].dden};
            if (trial >= {1'b0, pipe_reg[N-1].dden}) begin
                nxt.rem = diff[47:0];
                nxt.q   = {pipe_reg[N-1].q[62:0], 1'b1};
            end else begin
                nxt.rem = trial[47:0];
                nxt.q   = {pipe_reg[N-1].q[62:0], 1'b0};
            end
            nxt.dnum = {pipe_reg[N-1].dnum[62:0], 1'b0};
        end
        assign pipe_next[N] = nxt;
    end

    // G = tan(s)/L, saturated; zero divisor gives the limit
    always_comb begin
        item_t              it;
        logic signed [63:0] mag;
        it  = pipe_reg[STG_G-1];
        mag = (it.q[63:62] != 2'b00) ? LIM : $signed(it.q);
        if (it.gzero) begin
            it.g = '0;
        end else begin
            it.g = it.gneg ? -mag : mag;
        end
        pipe_next[STG_G] = it;
    end

    // Products G*U (split), G*r, U*dt
    always_comb begin
        item_t it;
        it     = pipe_reg[STG_M2-1];
        it.pgh = $signed(it.g[63:31]) * it.u;
        it.pgl = $signed({1'b0, it.g[30:0]}) * it.u;
        it.pt  = it.g * $signed(ro_reg);
        it.pwd = it.u * $signed({1'b0, dt_reg});
        pipe_next[STG_M2] = it;
    end

    // Yaw rate, tan(slip), distance travelled
    always_comb begin
        item_t it;
        it    = pipe_reg[STG_R2-1];
        it.w  = sat62(((wide_t'(it.pgh) <<< 31) + wide_t'(it.pgl)) >>> 23);
        it.t  = sat62(wide_t'(it.pt) >>> 12);
        it.wd = {it.pwd[50], it.pwd[50:16]};
        pipe_next[STG_R2] = it;
    end

    // Products w*dt and W*T (split)
    always_comb begin
        item_t it;
        it     = pipe_reg[STG_M3-1];
        it.pw  = it.w * $signed({1'b0, dt_reg});
        it.pth = $signed(it.t[63:31]) * it.wd;
        it.ptl = $signed({1'b0, it.t[30:0]}) * it.wd;
        pipe_next[STG_M3] = it;
    end

    // Heading change, mid-step angle, lateral term
    always_comb begin
        item_t              it;
        logic signed [63:0] hd;
        it    = pipe_reg[STG_R3-1];
        hd    = sat62(wide_t'(it.pw) >>> 16);
        it.dh = sat32(65'(hd));
        it.p  = sat62(wide_t'(it.pw) >>> 11);
        it.wt = sat62(((wide_t'(it.pth) <<< 31) + wide_t'(it.ptl)) >>> 23);
        pipe_next[STG_R3] = it;
    end

    // Magnitude of the mid-step angle
    always_comb begin
        item_t              it;
        logic signed [63:0] mag;
        it      = pipe_reg[STG_MA-1];
        mag     = it.p[63] ? -it.p : it.p;
        it.pneg = it.p[63];
        it.mr   = mag[62:0];
        pipe_next[STG_MA] = it;
    end

    // Reduction modulo 2*pi: reciprocal products, upper and lower halves
    always_comb begin
        item_t it;
        it     = pipe_reg[STG_RP-1];
        it.rph = it.mr[62:31] * RECIP_2PI;
        it.rpl = it.mr[30:0] * RECIP_2PI;
        pipe_next[STG_RP] = it;
    end

    // Quotient estimate, at most one below the true quotient
    always_comb begin
        item_t       it;
        logic [94:0] qs;
        it    = pipe_reg[STG_RQ-1];
        qs    = {it.rph, 31'd0} + {32'd0, it.rpl};
        it.rq = qs[94:64];
        pipe_next[STG_RQ] = it;
    end

    // Multiple of 2*pi to take away
    always_comb begin
        item_t it;
        it     = pipe_reg[STG_RM-1];
        it.rqc = it.rq * TWO_PI_33;
        pipe_next[STG_RM] = it;
    end

    // Remainder below 2*(2*pi) fits 35 bits; one correcting subtract
    always_comb begin
        item_t       it;
        logic [34:0] rd;
        it = pipe_reg[STG_RC-1];
        rd = it.mr[34:0] - it.rqc[34:0];
        if (rd >= {2'b00, TWO_PI_33}) begin
            rd = rd - {2'b00, TWO_PI_33};
        end
        it.mr = {28'd0, rd};
        pipe_next[STG_RC] = it;
    end

    // Restore sign, fold for the second CORDIC
    always_comb begin
        item_t             it;
        logic signed [ZW-1:0] v;
        fold_t             f;
        it      = pipe_reg[STG_F2-1];
        v       = $signed({2'b00, it.mr[32:0]});
        f       = fold_angle(it.pneg ? -v : v);
        it.x    = CORDIC_GAIN;
        it.y    = '0;
        it.z    = f.z;
        it.flip = f.flip;
        pipe_next[STG_F2] = it;
    end

    // Rotation products
    always_comb begin
        item_t              it;
        logic signed [33:0] cp;
        logic signed [33:0] sp;
        it     = pipe_reg[STG_M4-1];
        cp     = it.flip ? -it.x : it.x;
        sp     = it.flip ? -it.y : it.y;
        it.cpa = it.wd * cp;
        it.spa = it.wd * sp;
        it.wch = $signed(it.wt[63:31]) * cp;
        it.wcl = $signed({1'b0, it.wt[30:0]}) * cp;
        it.wsh = $signed(it.wt[63:31]) * sp;
        it.wsl = $signed({1'b0, it.wt[30:0]}) * sp;
        pipe_next[STG_M4] = it;
    end

    // Scale and clamp each term
    always_comb begin
        item_t it;
        it    = pipe_reg[STG_R4-1];
        it.a1 = sat62(wide_t'(it.cpa) >>> 33);
        it.b1 = sat62(((wide_t'(it.wsh) <<< 31) + wide_t'(it.wsl)) >>> 30);
        it.a2 = sat62(wide_t'(it.spa) >>> 33);
        it.b2 = sat62(((wide_t'(it.wch) <<< 31) + wide_t'(it.wcl)) >>> 30);
        pipe_next[STG_R4] = it;
    end

    // Combine into dx, dy
    always_comb begin
        item_t it;
        it    = pipe_reg[STG_OUT-1];
        it.dx = sat32(65'(it.a1) - 65'(it.b1));
        it.dy = sat32(65'(it.a2) + 65'(it.b2));
        pipe_next[STG_OUT] = it;
    end

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted request did not enter the pipe");

    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] |-> (pipe_reg[0].z <= Q30_HALF_PI) && (pipe_reg[0].z >= -Q30_HALF_PI))
        else $error("folded steering angle out of range");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[STG_G-1] && (pipe_reg[STG_G-1].dden != '0)
        |-> pipe_reg[STG_G-1].rem < pipe_reg[STG_G-1].dden)
        else $error("divider remainder not below divisor");

    a_mod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[STG_F2-1] |-> {1'b0, pipe_reg[STG_F2-1].mr} < TWO_PI_U)
        else $error("angle reduction left a remainder of 2*pi or more");
`endif

endmodule

// File: tb/bpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_checker - pose delta predictor and result scoreboard
// Watches the register, request and result channels of bicycle_pose_delta,
// keeps its own copy of the registers, works out dx, dy and dheading for
// every accepted request and compares each result with the oldest forecast.
// ----------------------------------------------------------------------------
module bpd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] speed, [31:16] steer_angle
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,    // [31:0] delta_x, [63:32] delta_y,
                                    // [95:64] delta_heading
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);
    import bpd_pkg::*;

    localparam longint SAT_LIM   = 64'sh4000_0000_0000_0000;
    localparam longint ANG_PI    = 64'sd3373259426;
    localparam longint ANG_HPI   = 64'sd1686629713;
    localparam longint ANG_2PI   = 64'sd6746518852;
    localparam longint ROT_GAIN  = 64'sd652032874;

    localparam longint ROT_ATAN [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    typedef struct {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dh;
    } pose_delta_t;

    logic [15:0]  wheel_base;
    logic [15:0]  rear_offset;
    logic [15:0]  step_time;
    pose_delta_t  pose_q[$];

    // floor(a*b / 2^k) from the full product, clamped to +-2^62
    function automatic longint prod_shift(input longint a, input longint b,
                                          input int k);
        logic signed [127:0] pr;
        pr = 128'(a) * 128'(b);
        pr = pr >>> k;
        if (pr > 128'(SAT_LIM)) begin
            return SAT_LIM;
        end else if (pr < -128'(SAT_LIM)) begin
            return -SAT_LIM;
        end
        return pr[63:0];
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Rotation CORDIC, Q30 angle in, Q30 cos and sin out
    function automatic void rot_sincos(input longint ang, output longint c,
                                       output longint s);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit     flip;
        z    = ang % ANG_2PI;
        x    = ROT_GAIN;
        y    = 0;
        flip = 1'b0;
        if (z > ANG_PI) begin
            z -= ANG_2PI;
        end else if (z < -ANG_PI) begin
            z += ANG_2PI;
        end
        if (z > ANG_HPI) begin
            z -= ANG_PI;
            flip = 1'b1;
        end else if (z < -ANG_HPI) begin
            z += ANG_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= ROT_ATAN[i];
            end else begin
                x += ys;
                y -= xs;
                z += ROT_ATAN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic pose_delta_t predict_pose(input logic signed [15:0] spd,
                                                 input logic signed [15:0] steer);
        longint      len, roff, dt, cs, ss, cp, sp;
        longint      u, g, t, w, p, wd, wt, num, den;
        pose_delta_t r;
        len  = wheel_base;
        roff = longint'(signed'(rear_offset));
        dt   = step_time;
        if (len == 0) begin
            len = 1;
        end
        rot_sincos(longint'(steer) * 131072, cs, ss);
        u   = (longint'(spd) * ((64'sd1 << 30) + cs)) >>> 16;
        num = ss * 64'sd4294967296;
        den = len * cs;
        if (den == 0) begin
            g = num > 0 ? SAT_LIM : (num < 0 ? -SAT_LIM : 0);
        end else begin
            g = num / den;
            if (g > SAT_LIM) g = SAT_LIM;
            if (g < -SAT_LIM) g = -SAT_LIM;
        end
        t  = prod_shift(g, roff, 12);
        w  = prod_shift(g, u, 23);
        p  = prod_shift(w, dt, 11);
        rot_sincos(p, cp, sp);
        wd = prod_shift(u, dt, 16);
        wt = prod_shift(wd, t, 23);
        r.dx = clip32(prod_shift(wd, cp, 33) - prod_shift(wt, sp, 30));
        r.dy = clip32(prod_shift(wd, sp, 33) + prod_shift(wt, cp, 30));
        r.dh = clip32(prod_shift(w, dt, 16));
        return r;
    endfunction

    // Register copy, forecasts and comparison
    always @(posedge aclk) begin
        pose_delta_t e;
        pose_delta_t a;
        if (!aresetn) begin
            wheel_base  <= WHEEL_BASE_RST;
            rear_offset <= REAR_OFFSET_RST;
            step_time   <= STEP_TIME_RST;
            pose_q.delete();
            errors      <= 0;
            pending     <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WHEEL_BASE:  wheel_base  <= cfg_data;
                    REG_REAR_OFFSET: rear_offset <= cfg_data;
                    REG_STEP_TIME:   step_time   <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pose_q.push_back(predict_pose(s_tdata[15:0], s_tdata[31:16]));
            end
            if (m_tvalid && m_tready) begin
                a.dx = m_tdata[31:0];
                a.dy = m_tdata[63:32];
                a.dh = m_tdata[95:64];
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected result dx=%0d dy=%0d dh=%0d",
                             $time, a.dx, a.dy, a.dh);
                    errors <= errors + 1;
                end else begin
                    e = pose_q.pop_front();
                    if (e.dx !== a.dx || e.dy !== a.dy || e.dh !== a.dh) begin
                        $display("%0t: delta mismatch expected %0d %0d %0d got %0d %0d %0d",
                                 $time, e.dx, e.dy, e.dh, a.dx, a.dy, a.dh);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= pose_q.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for bicycle_pose_delta
// Drives directed corner requests, then phases of random requests under a
// range of wheel base, rear offset and step settings, with random gaps and
// result stalls; the checker forecasts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import bpd_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         SETTLE     = 200;
    localparam int         PHASE_REQS = 215;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          errors;
    int          pending;

    logic        req_took = 1'b0;
    logic        res_took = 1'b0;
    logic        cfg_took = 1'b0;
    bit          no_gaps = 1'b0;
    int          stall_left = 0;
    int          stall_n;

    always #5 aclk = ~aclk;

    bicycle_pose_delta dut (.*);

    bpd_checker u_chk (.*);

    always @(posedge aclk) begin
        req_took <= s_tvalid && s_tready;
        res_took <= m_tvalid && m_tready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    // Result side back-pressure, drawn per accepted result
    always @(negedge aclk) begin
        if (res_took) begin
            stall_n = no_gaps ? 0 : $urandom_range(0, 7);
        end else begin
            stall_n = stall_left;
        end
        if (stall_n > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_n - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end
    end

    // One request; valid stays high into the next call when there is no gap
    task automatic send_state(input logic [15:0] spd, input logic [15:0] steer);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {steer, spd};
        do @(negedge aclk); while (!req_took);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Let the pipe empty before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_steer();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 12868 + 40) - 0);
            1: v = 16'(12868 + $urandom_range(0, 80) - 40);
            2: v = 16'($urandom_range(0, 6000) - 3000);
            default: v = 16'($urandom);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic logic [15:0] pick_speed();
        if ($urandom_range(0, 2) == 0) begin
            return 16'($urandom_range(0, 16384) - 8192);
        end
        return 16'($urandom);
    endfunction

    logic [15:0] corner_spd [8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001,
                                    16'hFFFF, 16'h1000, 16'hF000, 16'h5A5A};
    logic [15:0] corner_str [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'd12868,
                                    -16'd12868, 16'd12867, 16'd25736, 16'hA5A5};

    initial begin
        logic [15:0] wb, ro, st;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Corner requests at reset settings
        for (int i = 0; i < 8; i++) begin
            send_state(corner_spd[i], corner_str[i]);
            send_state(corner_spd[7 - i], corner_str[i]);
        end
        send_state(16'h7FFF, 16'd12868);
        send_state(16'h8000, -16'd12869);

        for (int ph = 1; ph <= 9; ph++) begin
            drain();
            case (ph)
                1: begin wb = 16'd1;     ro = 16'h7FFF; st = 16'hFFFF; end
                2: begin wb = 16'hFFFF;  ro = 16'h8000; st = 16'd1;    end
                3: begin wb = 16'd0;     ro = 16'hFFFF; st = 16'd0;    end
                default: begin
                    wb = $urandom_range(0, 1) ? 16'($urandom_range(1, 16384))
                                              : 16'($urandom_range(1, 65535));
                    ro = 16'($urandom);
                    st = 16'($urandom_range(1, 65535));
                end
            endcase
            write_reg(REG_WHEEL_BASE, wb);
            write_reg(REG_REAR_OFFSET, ro);
            write_reg(REG_STEP_TIME, st);
            if (ph == 4) write_reg(REG_UNUSED, 16'($urandom));
            no_gaps = (ph % 3 == 1);
            for (int i = 0; i < PHASE_REQS; i++) begin
                // Hold off once until every forecast has been met
                if (ph == 5 && i == 100) begin
                    drain();
                end
                if (ph == 3 && i < 8) begin
                    send_state(corner_spd[i], corner_str[i]);
                end else begin
                    send_state(pick_speed(), pick_steer());
                end
            end
        end

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (errors == 0) begin
            $display("bicycle_pose_delta test passed");
        end else begin
            $display("bicycle_pose_delta test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("bicycle_pose_delta test failed");
        $finish;
    end

endmodule
